// ----- sv/gofr_pkg.sv -----
package gofr_pkg;

  localparam int MAX_REPORT = 80;
  localparam int BT_REPORT_BYTES_DEFAULT = 78;
  localparam int USB_REPORT_BYTES_DEFAULT = 63;

  // link modes
  localparam logic [1:0] LINK_USB = 2'd0;
  localparam logic [1:0] LINK_BT  = 2'd1;

  // requests
  localparam logic [1:0] CMD_RUMBLE      = 2'd0;
  localparam logic [1:0] CMD_LIGHT_BAR   = 2'd1;
  localparam logic [1:0] CMD_PLAYER_LEDS = 2'd2;
  localparam logic [1:0] CMD_TRIGGER     = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_BAD_LINK     = 2'd1;
  localparam logic [1:0] STATUS_SHORT_BUFFER = 2'd2;
  localparam logic [1:0] STATUS_UNSUPPORTED  = 2'd3;

  // configuration register indexes
  localparam logic CFG_LINK_MODE       = 1'b0;
  localparam logic CFG_BUFFER_CAPACITY = 1'b1;

  // report bytes
  localparam logic [7:0] BT_REPORT_ID    = 8'h31;
  localparam logic [7:0] USB_REPORT_ID   = 8'h02;
  localparam logic [7:0] BT_TAG          = 8'h10;
  localparam logic [7:0] RUMBLE_FLAGS    = 8'h03;
  localparam logic [7:0] LIGHT_BAR_FLAG  = 8'h04;
  localparam logic [7:0] PLAYER_LED_FLAG = 8'h10;
  localparam logic [4:0] PLAYER_BITS     = 5'h1F;
  localparam logic [7:0] CRC_SEED_BYTE   = 8'hA2;

  // offsets inside the common block
  localparam int OFS_FLAG0  = 0;
  localparam int OFS_FLAG1  = 1;
  localparam int OFS_WEAK   = 2;
  localparam int OFS_STRONG = 3;
  localparam int OFS_LEDS   = 43;
  localparam int OFS_RED    = 44;
  localparam int OFS_GREEN  = 45;
  localparam int OFS_BLUE   = 46;
  localparam int BT_BASE    = 3;
  localparam int USB_BASE   = 1;

  // microprogram steps
  typedef enum logic [1:0] {
    STEP_WAIT,
    STEP_CHECK,
    STEP_EMIT,
    STEP_ERROR
  } step_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_SLOT_BUSY,
    COND_REFUSED,
    COND_LAST_WORD
  } cond_t;

  typedef struct packed {
    logic  take_input;
    logic  check;
    logic  emit_word;
    logic  emit_error;
    cond_t wait_cond;
    cond_t jump_cond;
    step_t jump_to;
    step_t next;
  } uword_t;

  typedef struct packed {
    logic take_input;
    logic check;
    logic issue_word;
    logic issue_error;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic slot_busy;
    logic refused;
    logic last_word;
  } sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_SEED = crc_byte(32'hFFFFFFFF, CRC_SEED_BYTE);

endpackage

// ----- sv/gamepad_output_report_framer_unit.sv -----
// Output report framer: one request (rumble, light bar or player LEDs) is taken on the
// input beat and comes out as a run of little-endian four-byte beats, the first report
// byte in bits 7..0, with last set on the final beat. USB framing gives USB_REPORT_BYTES
// bytes (16 beats at 63); Bluetooth framing gives BT_REPORT_BYTES bytes (20 beats at 78)
// with the sequence nibble and a CRC-32 in the last four bytes, folded in as the beats
// are built. A refused request (bad link mode, buffer_capacity below the report size,
// or an adaptive-trigger request) gives one beat with its status code and zero data.
// A request is taken in the wait step and checked in the check step, then issued at one
// beat per cycle while the output is not stalled, through the single output register
// that the microcoded sequencer fills. The next request is taken after the last beat
// has been issued. The user must write configuration via cfg_we, cfg_index and cfg_data
// only while no request is in flight; the block itself does not enforce this.
module gamepad_output_report_framer_unit #(
  parameter int BT_REPORT_BYTES  = gofr_pkg::BT_REPORT_BYTES_DEFAULT,
  parameter int USB_REPORT_BYTES = gofr_pkg::USB_REPORT_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] high_freq_level,
  input  logic signed [15:0] low_freq_level,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [7:0]         player_mask,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        report_word,
  output logic [2:0]         bytes_valid,
  output logic               last,
  output logic [1:0]         status
);

  gofr_pkg::ctrl_t ctrl;
  gofr_pkg::sts_t  sts;

  gofr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .sts  (sts),
    .ctrl (ctrl)
  );

  gofr_dp #(
    .BT_REPORT_BYTES  (BT_REPORT_BYTES),
    .USB_REPORT_BYTES (USB_REPORT_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .high_freq_level (high_freq_level),
    .low_freq_level  (low_freq_level),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .player_mask     (player_mask),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .report_word     (report_word),
    .bytes_valid     (bytes_valid),
    .last            (last),
    .status          (status)
  );

endmodule

// ----- sv/gofr_seq.sv -----
module gofr_seq (
  input  logic           clk,
  input  logic           rst,
  input  gofr_pkg::sts_t  sts,
  output gofr_pkg::ctrl_t ctrl
);

  gofr_pkg::step_t  step;
  gofr_pkg::step_t  step_next;
  gofr_pkg::uword_t uw;
  logic             hold;
  logic             jump;

  function automatic gofr_pkg::uword_t urom(input gofr_pkg::step_t s);
    gofr_pkg::uword_t u;
    u = '{take_input: 1'b0, check: 1'b0, emit_word: 1'b0, emit_error: 1'b0,
          wait_cond: gofr_pkg::COND_NEVER, jump_cond: gofr_pkg::COND_NEVER,
          jump_to: gofr_pkg::STEP_WAIT, next: gofr_pkg::STEP_WAIT};
    case (s)
      gofr_pkg::STEP_WAIT: begin
        u.take_input = 1'b1;
        u.wait_cond  = gofr_pkg::COND_NO_INPUT;
        u.next       = gofr_pkg::STEP_CHECK;
      end
      gofr_pkg::STEP_CHECK: begin
        u.check     = 1'b1;
        u.jump_cond = gofr_pkg::COND_REFUSED;
        u.jump_to   = gofr_pkg::STEP_ERROR;
        u.next      = gofr_pkg::STEP_EMIT;
      end
      gofr_pkg::STEP_EMIT: begin
        u.emit_word = 1'b1;
        u.wait_cond = gofr_pkg::COND_SLOT_BUSY;
        u.jump_cond = gofr_pkg::COND_LAST_WORD;
        u.jump_to   = gofr_pkg::STEP_WAIT;
        u.next      = gofr_pkg::STEP_EMIT;
      end
      gofr_pkg::STEP_ERROR: begin
        u.emit_error = 1'b1;
        u.wait_cond  = gofr_pkg::COND_SLOT_BUSY;
        u.next       = gofr_pkg::STEP_WAIT;
      end
      default: begin
        u.next = gofr_pkg::STEP_WAIT;
      end
    endcase
    return u;
  endfunction

  function automatic logic cond_true(input gofr_pkg::cond_t c, input gofr_pkg::sts_t s);
    logic r;
    case (c)
      gofr_pkg::COND_NEVER:     r = 1'b0;
      gofr_pkg::COND_NO_INPUT:  r = ~s.in_valid;
      gofr_pkg::COND_SLOT_BUSY: r = s.slot_busy;
      gofr_pkg::COND_REFUSED:   r = s.refused;
      gofr_pkg::COND_LAST_WORD: r = s.last_word;
      default:                  r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    uw   = urom(step);
    hold = cond_true(uw.wait_cond, sts);
    jump = cond_true(uw.jump_cond, sts);
  end

  // next step
  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (jump) begin
      step_next = uw.jump_to;
    end else begin
      step_next = uw.next;
    end
  end

  // control outputs
  always_comb begin
    ctrl.take_input  = uw.take_input;
    ctrl.check       = uw.check & ~hold;
    ctrl.issue_word  = uw.emit_word & ~hold;
    ctrl.issue_error = uw.emit_error & ~hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= gofr_pkg::STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- sv/gofr_dp.sv -----
module gofr_dp #(
  parameter int BT_REPORT_BYTES  = gofr_pkg::BT_REPORT_BYTES_DEFAULT,
  parameter int USB_REPORT_BYTES = gofr_pkg::USB_REPORT_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  gofr_pkg::ctrl_t     ctrl,
  output gofr_pkg::sts_t      sts,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] high_freq_level,
  input  logic signed [15:0] low_freq_level,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [7:0]         player_mask,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        report_word,
  output logic [2:0]         bytes_valid,
  output logic               last,
  output logic [1:0]         status
);

  localparam int BtSize   = (BT_REPORT_BYTES > gofr_pkg::MAX_REPORT) ?
                            gofr_pkg::MAX_REPORT : BT_REPORT_BYTES;
  localparam int UsbSize  = (USB_REPORT_BYTES > gofr_pkg::MAX_REPORT) ?
                            gofr_pkg::MAX_REPORT : USB_REPORT_BYTES;
  localparam int MaxWords = (gofr_pkg::MAX_REPORT + 3) / 4;
  localparam int WordW    = $clog2(MaxWords);
  localparam int PosW     = WordW + 2;

  localparam logic [7:0]       BtNominal  = 8'(BT_REPORT_BYTES);
  localparam logic [7:0]       UsbNominal = 8'(USB_REPORT_BYTES);
  localparam logic [WordW-1:0] BtLast     = WordW'((BtSize + 3) / 4 - 1);
  localparam logic [WordW-1:0] UsbLast    = WordW'((UsbSize + 3) / 4 - 1);
  localparam logic [PosW-1:0]  BtSizeP    = PosW'(BtSize);
  localparam logic [PosW-1:0]  UsbSizeP   = PosW'(UsbSize);
  localparam logic [PosW-1:0]  BtCrcPos   = PosW'(BtSize - 4);

  function automatic logic [7:0] level_to_byte(input logic signed [15:0] x);
    logic [21:0] scaled;
    logic [7:0]  r;
    scaled = 22'(x[13:0]) * 22'd255 + 22'd8192;
    if (x <= 16'sd0) begin
      r = 8'd0;
    end else if (x >= 16'sd16384) begin
      r = 8'd255;
    end else begin
      r = scaled[21:14];
    end
    return r;
  endfunction

  // configuration
  logic [1:0] link_mode;
  logic [7:0] buffer_capacity;
  logic [3:0] bt_seq_counter;

  // captured request
  logic [1:0]         cmd_r;
  logic signed [15:0] high_r;
  logic signed [15:0] low_r;
  logic [7:0]         red_r;
  logic [7:0]         green_r;
  logic [7:0]         blue_r;
  logic [4:0]         leds_r;

  // per-request working registers
  logic             is_bt;
  logic [1:0]       err_code;
  logic [7:0]       seq_byte;
  logic [7:0]       weak_byte;
  logic [7:0]       strong_byte;
  logic [WordW-1:0] word;
  logic [31:0]      crc;

  logic             link_bad;
  logic             cap_short;
  logic [1:0]       check_code;
  logic             bt_now;

  logic [PosW-1:0]  word_pos;
  logic [PosW-1:0]  base;
  logic [PosW-1:0]  size_p;
  logic [PosW-1:0]  remaining;
  logic [2:0]       valid_n;
  logic [PosW-1:0]  pos      [4];
  logic [7:0]       data_b   [4];
  logic             crc_slot [4];
  logic [31:0]      crc_next;
  logic [31:0]      crc_fin;
  logic [31:0]      word_out;
  logic [7:0]       fb;
  logic [1:0]       crc_idx;

  assign in_stall = ~ctrl.take_input;

  always_comb begin
    bt_now    = (link_mode == gofr_pkg::LINK_BT);
    link_bad  = (link_mode != gofr_pkg::LINK_USB) && !bt_now;
    cap_short = buffer_capacity < (bt_now ? BtNominal : UsbNominal);
    if (link_bad) begin
      check_code = gofr_pkg::STATUS_BAD_LINK;
    end else if (cap_short) begin
      check_code = gofr_pkg::STATUS_SHORT_BUFFER;
    end else if (cmd_r == gofr_pkg::CMD_TRIGGER) begin
      check_code = gofr_pkg::STATUS_UNSUPPORTED;
    end else begin
      check_code = gofr_pkg::STATUS_OK;
    end
  end

  always_comb begin
    sts.in_valid  = in_valid;
    sts.slot_busy = out_valid & out_stall;
    sts.refused   = (check_code != gofr_pkg::STATUS_OK);
    sts.last_word = (word == (is_bt ? BtLast : UsbLast));
  end

  // frame bytes of the current word, crc folded over the bytes ahead of the crc field
  always_comb begin
    word_pos  = {word, 2'b00};
    base      = is_bt ? PosW'(gofr_pkg::BT_BASE) : PosW'(gofr_pkg::USB_BASE);
    size_p    = is_bt ? BtSizeP : UsbSizeP;
    remaining = size_p - word_pos;
    valid_n   = (remaining >= PosW'(4)) ? 3'd4 : remaining[2:0];
    crc_next  = crc;
    for (int k = 0; k < 4; k++) begin
      pos[k] = word_pos + PosW'(k);
      fb = 8'h00;
      if (is_bt) begin
        if (pos[k] == PosW'(0)) fb = gofr_pkg::BT_REPORT_ID;
        if (pos[k] == PosW'(1)) fb = seq_byte;
        if (pos[k] == PosW'(2)) fb = gofr_pkg::BT_TAG;
      end else begin
        if (pos[k] == PosW'(0)) fb = gofr_pkg::USB_REPORT_ID;
      end
      case (cmd_r)
        gofr_pkg::CMD_RUMBLE: begin
          if (pos[k] == base + PosW'(gofr_pkg::OFS_FLAG0))  fb = gofr_pkg::RUMBLE_FLAGS;
          if (pos[k] == base + PosW'(gofr_pkg::OFS_WEAK))   fb = weak_byte;
          if (pos[k] == base + PosW'(gofr_pkg::OFS_STRONG)) fb = strong_byte;
        end
        gofr_pkg::CMD_LIGHT_BAR: begin
          if (pos[k] == base + PosW'(gofr_pkg::OFS_FLAG1)) fb = gofr_pkg::LIGHT_BAR_FLAG;
          if (pos[k] == base + PosW'(gofr_pkg::OFS_RED))   fb = red_r;
          if (pos[k] == base + PosW'(gofr_pkg::OFS_GREEN)) fb = green_r;
          if (pos[k] == base + PosW'(gofr_pkg::OFS_BLUE))  fb = blue_r;
        end
        gofr_pkg::CMD_PLAYER_LEDS: begin
          if (pos[k] == base + PosW'(gofr_pkg::OFS_FLAG1)) fb = gofr_pkg::PLAYER_LED_FLAG;
          if (pos[k] == base + PosW'(gofr_pkg::OFS_LEDS))  fb = {3'b000, leds_r};
        end
        default: ;
      endcase
      data_b[k]   = fb;
      crc_slot[k] = is_bt && (pos[k] >= BtCrcPos);
      if (is_bt && (pos[k] < BtCrcPos)) begin
        crc_next = gofr_pkg::crc_byte(crc_next, fb);
      end
    end
    crc_fin  = ~crc_next;
    word_out = 32'h0;
    for (int k = 0; k < 4; k++) begin
      crc_idx = 2'(pos[k] - BtCrcPos);
      if (3'(k) < valid_n) begin
        word_out[8*k +: 8] = crc_slot[k] ? crc_fin[8*crc_idx +: 8] : data_b[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode       <= gofr_pkg::LINK_USB;
      buffer_capacity <= 8'd78;
    end else if (cfg_we) begin
      if (cfg_index == gofr_pkg::CFG_LINK_MODE) begin
        link_mode <= cfg_data[1:0];
      end
      if (cfg_index == gofr_pkg::CFG_BUFFER_CAPACITY) begin
        buffer_capacity <= cfg_data;
      end
    end
  end

  // sequence advances once a Bluetooth link and the buffer pass the check, even for a refused request
  always_ff @(posedge clk) begin
    if (rst) begin
      bt_seq_counter <= 4'd0;
    end else if (ctrl.check && bt_now && !cap_short) begin
      bt_seq_counter <= bt_seq_counter + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r   <= cmd;
      high_r  <= high_freq_level;
      low_r   <= low_freq_level;
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      leds_r  <= player_mask[4:0] & gofr_pkg::PLAYER_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.check) begin
      is_bt       <= bt_now;
      err_code    <= check_code;
      seq_byte    <= {bt_seq_counter, 4'h0};
      weak_byte   <= level_to_byte(high_r);
      strong_byte <= level_to_byte(low_r);
      word        <= '0;
      crc         <= gofr_pkg::CRC_SEED;
    end else if (ctrl.issue_word) begin
      word <= word + WordW'(1);
      crc  <= crc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.issue_word || ctrl.issue_error) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue_word) begin
      report_word <= word_out;
      bytes_valid <= valid_n;
      last        <= sts.last_word;
      status      <= gofr_pkg::STATUS_OK;
    end else if (ctrl.issue_error) begin
      report_word <= 32'h0;
      bytes_valid <= 3'd0;
      last        <= 1'b1;
      status      <= err_code;
    end
  end

endmodule
